[rtl/core/pot_to_motor_servo_setpoint_defines.svh]
// assertion macros shared by the setpoint block checker
`ifndef POT_TO_MOTOR_SERVO_SETPOINT_DEFINES_SVH
`define POT_TO_MOTOR_SERVO_SETPOINT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define PTMSS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on aclk, off during reset
`define PTMSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/core/ptmss_pkg.sv]
// shared constants and types for the pot-to-motor/servo setpoint block
package ptmss_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // averaging history and sample width
    localparam int HISTORY_DEPTH = 10;
    localparam int SAMPLE_BITS   = 10;
    localparam int IN_W          = 10;
    localparam int SMP_W         = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int HIST_KEEP     = HISTORY_DEPTH - 1;
    localparam int SUM_W         = SMP_W + $clog2(HISTORY_DEPTH);

    // register widths
    localparam int SFS_W   = 8;
    localparam int ADC_W   = 10;
    localparam int BAND_W  = 7;
    localparam int RANGE_W = 8;
    localparam int OFS_W   = 7;
    localparam int CNT_W   = 16;

    // result widths
    localparam int SPD_W = 9;
    localparam int MAG_W = 8;
    localparam int RAW_W = 8;
    localparam int ANG_W = 9;

    // shared divider: two quotient bits per cycle
    localparam int DIV_RAW_W = imax(imax(SUM_W, SMP_W + SFS_W), imax(SMP_W + RANGE_W, CNT_W));
    localparam int DIV_W     = DIV_RAW_W + (DIV_RAW_W % 2);
    localparam int DVR_W     = ADC_W;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // shared multiplier operands (signed)
    localparam int MA_W = CNT_W + 1;
    localparam int MB_W = imax(SFS_W, RANGE_W) + 1;
    localparam int MP_W = MA_W + MB_W;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_FULL_SCALE = 4'd0,
        CFG_ADC_FULL_SCALE   = 4'd1,
        CFG_SPEED_BAND       = 4'd2,
        CFG_ANGLE_RANGE      = 4'd3,
        CFG_ANGLE_OFFSET     = 4'd4,
        CFG_MOTOR_PERIOD     = 4'd5,
        CFG_SERVO_MIN_COUNT  = 4'd6,
        CFG_SERVO_MAX_COUNT  = 4'd7
    } cfg_idx_t;

    localparam logic [SFS_W-1:0]   RST_SPEED_FULL_SCALE = 8'd198;
    localparam logic [ADC_W-1:0]   RST_ADC_FULL_SCALE   = 10'd1023;
    localparam logic [BAND_W-1:0]  RST_SPEED_BAND       = 7'd99;
    localparam logic [RANGE_W-1:0] RST_ANGLE_RANGE      = 8'd180;
    localparam logic [OFS_W-1:0]   RST_ANGLE_OFFSET     = 7'd90;
    localparam logic [CNT_W-1:0]   RST_MOTOR_PERIOD     = 16'd1999;
    localparam logic [CNT_W-1:0]   RST_SERVO_MIN_COUNT  = 16'd2250;
    localparam logic [CNT_W-1:0]   RST_SERVO_MAX_COUNT  = 16'd9000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/core/ptmss_div.sv]
// shared unsigned restoring divider, two quotient bits per cycle
module ptmss_div import ptmss_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVR_W-1:0]     rem_reg, rem_next;
    logic [DVR_W-1:0]     divisor_reg;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DVR_W:0]   t1, t2;
    logic [DVR_W-1:0] r1, r2;
    logic             ge1, ge2;

    // two chained compare-subtract steps
    always_comb begin
        t1  = {rem_reg, quo_reg[DIV_W-1]};
        ge1 = (t1 >= {1'b0, divisor_reg});
        r1  = ge1 ? DVR_W'(t1 - {1'b0, divisor_reg}) : t1[DVR_W-1:0];
        t2  = {r1, quo_reg[DIV_W-2]};
        ge2 = (t2 >= {1'b0, divisor_reg});
        r2  = ge2 ? DVR_W'(t2 - {1'b0, divisor_reg}) : t2[DVR_W-1:0];
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            quo_next = req.dividend;
            cnt_next = DIV_CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            rem_next  = r2;
            quo_next  = {quo_reg[DIV_W-3:0], ge1, ge2};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) begin
            divisor_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/core/pot_to_motor_servo_setpoint.sv]
// top level: averaged pot samples to H-bridge pins and motor/servo pulse widths
//
// Input channel (s_valid/s_ready) takes one beat with a speed and an angle
// sample. Each channel is averaged with its nine previous samples, then
// scaled to speed, angle, bridge pins and the two pulse widths.
// Result channel (m_valid/m_ready) gives one beat per input beat, in order.
// Config channel (cfg_valid/cfg_ready) writes one register per beat by index;
// cfg_ready is always high and unknown indexes are dropped. Write it only
// while no item is in flight.
// From acceptance to the result register, a beat goes through six divisions
// on the shared radix-4 divider and four passes through the shared
// multiplier, then is loaded into the output register.
// s_ready is high only while the sequencer is idle, so the block takes a new
// beat only after the last one has been loaded into the output register.
// The result sits in an output register: a stalled receiver does not stop
// the next beat from being accepted and worked on; the sequencer only waits
// at its last step until the output register is free.
// Synchronous active-low reset clears the history, the held direction pins,
// the sequencer and m_valid, and loads the register defaults.
module pot_to_motor_servo_setpoint import ptmss_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IN_W-1:0]         s_speed_sample,
    input  logic [IN_W-1:0]         s_angle_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SPD_W-1:0] m_speed_signed,
    output logic [MAG_W-1:0]        m_speed_magnitude,
    output logic [RAW_W-1:0]        m_angle_raw,
    output logic signed [ANG_W-1:0] m_angle_signed,
    output logic                    m_bridge_enable,
    output logic                    m_bridge_in1,
    output logic                    m_bridge_in2,
    output logic [CNT_W-1:0]        m_motor_pulse,
    output logic [CNT_W-1:0]        m_servo_pulse,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L_SAVG, ST_W_SAVG,
        ST_L_AAVG, ST_W_AAVG,
        ST_M_S, ST_L_Q, ST_W_Q,
        ST_M_A, ST_L_RAW, ST_W_RAW,
        ST_L_MP, ST_W_MP, ST_M_MP,
        ST_L_SP, ST_W_SP, ST_M_SP,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [SFS_W-1:0]   sfs_reg;
    logic [ADC_W-1:0]   adc_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [OFS_W-1:0]   ofs_reg;
    logic [CNT_W-1:0]   mper_reg;
    logic [CNT_W-1:0]   smin_reg;
    logic [CNT_W-1:0]   smax_reg;

    // history: taps plus running sum of the kept samples
    logic [SMP_W-1:0] spd_hist_reg [HIST_KEEP];
    logic [SMP_W-1:0] ang_hist_reg [HIST_KEEP];
    logic [SUM_W-1:0] spd_run_reg, ang_run_reg;
    logic [SUM_W-1:0] sum_s_reg, sum_a_reg;
    logic             last_in1_reg, last_in2_reg;

    // working registers
    logic [SMP_W-1:0]         savg_reg, aavg_reg;
    logic signed [SPD_W:0]    spd_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic [ANG_W-1:0]         ang_reg;
    logic [CNT_W-1:0]         mq_reg;
    logic [CNT_W-1:0]         mpulse_reg;
    logic signed [CNT_W:0]    span_reg;
    logic signed [MP_W-1:0]   prod_reg;

    // output registers
    logic                    m_valid_reg;
    logic signed [SPD_W-1:0] o_spd_reg;
    logic [MAG_W-1:0]        o_mag_reg;
    logic [RAW_W-1:0]        o_raw_reg;
    logic [ANG_W-1:0]        o_ang_reg;
    logic                    o_en_reg, o_in1_reg, o_in2_reg;
    logic [CNT_W-1:0]        o_mp_reg, o_sp_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [SMP_W-1:0]       s_smp, a_smp;
    logic [ADC_W-1:0]       adc_nz;
    logic [BAND_W-1:0]      band_nz;
    logic [RANGE_W-1:0]     range_nz;
    logic signed [CNT_W:0]  span_diff;
    logic [CNT_W:0]         span_abs_x;
    logic                   span_neg;
    logic [SPD_W:0]         q_lim;
    logic [SPD_W-1:0]       q_cl;
    logic signed [SPD_W:0]  spd_x;
    logic [SPD_W:0]         spd_negx;
    logic [MAG_W-1:0]       spd_mag;
    logic [RAW_W-1:0]       raw_x;
    logic [ANG_W-1:0]       ang_x;
    logic signed [CNT_W:0]  span_q;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic [CNT_W-1:0]       mp_sat;
    logic signed [MP_W:0]   sp_sum;
    logic [CNT_W-1:0]       sp_sat;
    logic                   out_free;

    ptmss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_smp = s_speed_sample[SMP_W-1:0];
    assign a_smp = s_angle_sample[SMP_W-1:0];

    // zero divisors count as one
    assign adc_nz   = (adc_reg == '0) ? ADC_W'(1) : adc_reg;
    assign band_nz  = (band_reg == '0) ? BAND_W'(1) : band_reg;
    assign range_nz = (range_reg == '0) ? RANGE_W'(1) : range_reg;

    // servo count span, divided as a magnitude and signed back afterwards
    assign span_diff  = $signed({1'b0, smax_reg}) - $signed({1'b0, smin_reg});
    assign span_neg   = span_diff[CNT_W];
    assign span_abs_x = span_neg ? (CNT_W+1)'(-span_diff) : span_diff;
    assign span_q     = span_neg ? -$signed({1'b0, div_rsp.quotient[CNT_W-1:0]})
                                 : $signed({1'b0, div_rsp.quotient[CNT_W-1:0]});

    // speed from the scaled quotient
    assign q_lim  = (SPD_W+1)'(255) + (SPD_W+1)'(band_reg);
    assign q_cl   = (div_rsp.quotient > DIV_W'(q_lim)) ? q_lim[SPD_W-1:0]
                                                       : div_rsp.quotient[SPD_W-1:0];
    assign spd_x    = $signed({1'b0, q_cl}) - $signed({{(SPD_W+1-BAND_W){1'b0}}, band_reg});
    assign spd_negx = -spd_x;
    assign spd_mag  = spd_x[SPD_W] ? spd_negx[MAG_W-1:0] : spd_x[MAG_W-1:0];

    // angle from the scaled quotient
    assign raw_x = (div_rsp.quotient > DIV_W'(255)) ? {RAW_W{1'b1}}
                                                   : div_rsp.quotient[RAW_W-1:0];
    assign ang_x = {1'b0, raw_x} - {{(ANG_W-OFS_W){1'b0}}, ofs_reg};

    // divider operand select
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(sum_s_reg);
        div_req.divisor  = DVR_W'(HISTORY_DEPTH);
        case (state_reg)
            ST_L_SAVG: begin
                div_req.start = 1'b1;
            end
            ST_L_AAVG: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sum_a_reg);
            end
            ST_L_Q, ST_L_RAW: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[DIV_W-1:0];
                div_req.divisor  = adc_nz;
            end
            ST_L_MP: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(mper_reg);
                div_req.divisor  = DVR_W'(band_nz);
            end
            ST_L_SP: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(span_abs_x[CNT_W-1:0]);
                div_req.divisor  = DVR_W'(range_nz);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // multiplier operand select
    always_comb begin
        case (state_reg)
            ST_M_S: begin
                mul_a = $signed({{(MA_W-SMP_W){1'b0}}, savg_reg});
                mul_b = $signed({{(MB_W-SFS_W){1'b0}}, sfs_reg});
            end
            ST_M_A: begin
                mul_a = $signed({{(MA_W-SMP_W){1'b0}}, aavg_reg});
                mul_b = $signed({{(MB_W-RANGE_W){1'b0}}, range_reg});
            end
            ST_M_MP: begin
                mul_a = $signed({1'b0, mq_reg});
                mul_b = $signed({{(MB_W-MAG_W){1'b0}}, mag_reg});
            end
            default: begin
                mul_a = span_reg;
                mul_b = $signed({{(MB_W-RAW_W){1'b0}}, raw_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // saturation of the two pulse widths
    assign mp_sat = (prod_reg[MP_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : prod_reg[CNT_W-1:0];
    assign sp_sum = {prod_reg[MP_W-1], prod_reg}
                  + $signed({{(MP_W+1-CNT_W){1'b0}}, smin_reg});
    assign sp_sat = sp_sum[MP_W] ? '0
                  : ((sp_sum[MP_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : sp_sum[CNT_W-1:0]);

    assign out_free = !m_valid_reg || m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sfs_reg   <= RST_SPEED_FULL_SCALE;
            adc_reg   <= RST_ADC_FULL_SCALE;
            band_reg  <= RST_SPEED_BAND;
            range_reg <= RST_ANGLE_RANGE;
            ofs_reg   <= RST_ANGLE_OFFSET;
            mper_reg  <= RST_MOTOR_PERIOD;
            smin_reg  <= RST_SERVO_MIN_COUNT;
            smax_reg  <= RST_SERVO_MAX_COUNT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPEED_FULL_SCALE: sfs_reg   <= cfg_data[SFS_W-1:0];
                CFG_ADC_FULL_SCALE:   adc_reg   <= cfg_data[ADC_W-1:0];
                CFG_SPEED_BAND:       band_reg  <= cfg_data[BAND_W-1:0];
                CFG_ANGLE_RANGE:      range_reg <= cfg_data[RANGE_W-1:0];
                CFG_ANGLE_OFFSET:     ofs_reg   <= cfg_data[OFS_W-1:0];
                CFG_MOTOR_PERIOD:     mper_reg  <= cfg_data[CNT_W-1:0];
                CFG_SERVO_MIN_COUNT:  smin_reg  <= cfg_data[CNT_W-1:0];
                CFG_SERVO_MAX_COUNT:  smax_reg  <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer, history and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_in1_reg <= 1'b0;
            last_in2_reg <= 1'b0;
            spd_run_reg  <= '0;
            ang_run_reg  <= '0;
            for (int k = 0; k < HIST_KEEP; k++) begin
                spd_hist_reg[k] <= '0;
                ang_hist_reg[k] <= '0;
            end
        end else begin
            // in the final step a free output register takes the new beat instead
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sum_s_reg   <= SUM_W'(s_smp) + spd_run_reg;
                        sum_a_reg   <= SUM_W'(a_smp) + ang_run_reg;
                        spd_run_reg <= spd_run_reg + SUM_W'(s_smp)
                                     - SUM_W'(spd_hist_reg[HIST_KEEP-1]);
                        ang_run_reg <= ang_run_reg + SUM_W'(a_smp)
                                     - SUM_W'(ang_hist_reg[HIST_KEEP-1]);
                        for (int k = HIST_KEEP - 1; k > 0; k--) begin
                            spd_hist_reg[k] <= spd_hist_reg[k-1];
                            ang_hist_reg[k] <= ang_hist_reg[k-1];
                        end
                        spd_hist_reg[0] <= s_smp;
                        ang_hist_reg[0] <= a_smp;
                        state_reg       <= ST_L_SAVG;
                    end
                end
                ST_L_SAVG: state_reg <= ST_W_SAVG;
                ST_W_SAVG: begin
                    if (div_rsp.done) begin
                        savg_reg  <= div_rsp.quotient[SMP_W-1:0];
                        state_reg <= ST_L_AAVG;
                    end
                end
                ST_L_AAVG: state_reg <= ST_W_AAVG;
                ST_W_AAVG: begin
                    if (div_rsp.done) begin
                        aavg_reg  <= div_rsp.quotient[SMP_W-1:0];
                        state_reg <= ST_M_S;
                    end
                end
                ST_M_S: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_L_Q;
                end
                ST_L_Q: state_reg <= ST_W_Q;
                ST_W_Q: begin
                    if (div_rsp.done) begin
                        spd_reg <= spd_x;
                        mag_reg <= spd_mag;
                        // direction pins hold their last values at zero speed
                        if (spd_x != '0) begin
                            last_in1_reg <= spd_x[SPD_W];
                            last_in2_reg <= !spd_x[SPD_W];
                        end
                        state_reg <= ST_M_A;
                    end
                end
                ST_M_A: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_L_RAW;
                end
                ST_L_RAW: state_reg <= ST_W_RAW;
                ST_W_RAW: begin
                    if (div_rsp.done) begin
                        raw_reg   <= raw_x;
                        ang_reg   <= ang_x;
                        state_reg <= ST_L_MP;
                    end
                end
                ST_L_MP: state_reg <= ST_W_MP;
                ST_W_MP: begin
                    if (div_rsp.done) begin
                        mq_reg    <= div_rsp.quotient[CNT_W-1:0];
                        state_reg <= ST_M_MP;
                    end
                end
                ST_M_MP: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_L_SP;
                end
                ST_L_SP: begin
                    mpulse_reg <= mp_sat;
                    state_reg  <= ST_W_SP;
                end
                ST_W_SP: begin
                    if (div_rsp.done) begin
                        span_reg  <= span_q;
                        state_reg <= ST_M_SP;
                    end
                end
                ST_M_SP: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        o_spd_reg   <= spd_reg[SPD_W-1:0];
                        o_mag_reg   <= mag_reg;
                        o_raw_reg   <= raw_reg;
                        o_ang_reg   <= ang_reg;
                        o_en_reg    <= (spd_reg != '0);
                        o_in1_reg   <= last_in1_reg;
                        o_in2_reg   <= last_in2_reg;
                        o_mp_reg    <= mpulse_reg;
                        o_sp_reg    <= sp_sat;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_speed_signed    = o_spd_reg;
    assign m_speed_magnitude = o_mag_reg;
    assign m_angle_raw       = o_raw_reg;
    assign m_angle_signed    = $signed(o_ang_reg);
    assign m_bridge_enable   = o_en_reg;
    assign m_bridge_in1      = o_in1_reg;
    assign m_bridge_in2      = o_in2_reg;
    assign m_motor_pulse     = o_mp_reg;
    assign m_servo_pulse     = o_sp_reg;

endmodule

[rtl/core/ptmss_chk.sv]
// port-level checker for the setpoint block, bound to the top level
`include "pot_to_motor_servo_setpoint_defines.svh"

module ptmss_chk import ptmss_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [SPD_W-1:0] m_speed_signed,
    input logic [MAG_W-1:0]        m_speed_magnitude,
    input logic                    m_bridge_enable,
    input logic                    m_bridge_in1,
    input logic                    m_bridge_in2,
    input logic [CNT_W-1:0]        m_motor_pulse,
    input logic [CNT_W-1:0]        m_servo_pulse
);

    // bridge is off exactly when the speed is zero
    `PTMSS_ASSERT_IMPL(a_enable_zero, m_valid, m_bridge_enable == (m_speed_signed != 9'sd0))

    // with the bridge on, the pins follow the speed sign and are opposite
    `PTMSS_ASSERT_IMPL(a_dir_sign, m_valid && m_bridge_enable, (m_bridge_in1 == m_speed_signed[8]) && (m_bridge_in2 != m_bridge_in1))

    // magnitude matches a non-negative speed
    `PTMSS_ASSERT_IMPL(a_mag, m_valid && !m_speed_signed[8], m_speed_magnitude == m_speed_signed[7:0])

    // one item at a time: busy right after an input beat
    `PTMSS_ASSERT_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready)

    // a stalled result beat holds
    `PTMSS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_motor_pulse) && $stable(m_servo_pulse))

endmodule

bind pot_to_motor_servo_setpoint ptmss_chk u_ptmss_chk (.*);
